@@ rtl/sit_pkg.sv @@
package sit_pkg;

  localparam logic [15:0] NO_READING = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_SET_TEMP  = 3'd1,
    OP_SET_HUM   = 3'd2,
    OP_LOOKUP    = 3'd3,
    OP_READ_SLOT = 3'd4,
    OP_CLEAR     = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [63:0] id;
    logic [15:0] temp;
    logic [15:0] hum;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

@@ rtl/sit_cell.sv @@
module sit_cell (
  input  logic              clk,
  input  logic              rst,
  input  sit_pkg::cell_ctl_t ctl,
  input  sit_pkg::entry_t   din,
  output sit_pkg::entry_t   dout
);

  sit_pkg::entry_t entry;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      entry <= '0;
    end else if (ctl.shift) begin
      entry <= din;
    end
  end

  assign dout = entry;

endmodule

@@ rtl/sit_ctrl.sv @@
module sit_ctrl #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic [63:0]        in_id,
  input  logic [15:0]        in_reading,
  input  logic [7:0]         in_pos,
  input  sit_pkg::entry_t    head,
  output sit_pkg::entry_t    head_new,
  output sit_pkg::cell_ctl_t ctl,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic [15:0]        out_temp,
  output logic [15:0]        out_hum,
  output logic [63:0]        out_id,
  output logic [8:0]         out_fill
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  sit_pkg::state_e state, state_next;
  sit_pkg::kind_e  kind_r;
  logic [63:0]     key_r;
  logic [15:0]     rd_r;
  logic [7:0]      pos_r;
  logic [IW-1:0]   cnt;
  logic            hit;
  logic            free_found;
  logic [IW-1:0]   free_idx;
  logic            placed;
  logic [15:0]     htemp;
  logic [15:0]     hhum;
  logic [63:0]     rid;
  logic [FW-1:0]   fill;

  logic            in_acc;
  logic            last;
  logic            match;
  logic            head_free;
  logic            pos_ok;
  logic            res_ok;
  logic            out_load;
  sit_pkg::kind_e  in_kind_e;

  assign in_kind_e = sit_pkg::kind_e'(in_kind);
  assign in_ready  = (state == sit_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign last      = (cnt == LAST);
  assign match     = (key_r != 64'd0) && (head.id == key_r);
  assign head_free = (head.id == 64'd0);
  assign pos_ok    = (9'(pos_r) < 9'(SLOTS));
  assign out_load  = (state == sit_pkg::ST_FINISH) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sit_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_kind_e)
            sit_pkg::OP_ADD, sit_pkg::OP_SET_TEMP, sit_pkg::OP_SET_HUM,
            sit_pkg::OP_LOOKUP, sit_pkg::OP_READ_SLOT: state_next = sit_pkg::ST_SCAN;
            default: state_next = sit_pkg::ST_FINISH;
          endcase
        end
      end
      sit_pkg::ST_SCAN: begin
        if (last) begin
          // an add that missed and saw a free slot goes around once more to drop the id in place
          if ((kind_r == sit_pkg::OP_ADD) && (key_r != 64'd0) && !(hit || match) &&
              (free_found || head_free)) begin
            state_next = sit_pkg::ST_PLACE;
          end else begin
            state_next = sit_pkg::ST_FINISH;
          end
        end
      end
      sit_pkg::ST_PLACE: begin
        if (last) begin
          state_next = sit_pkg::ST_FINISH;
        end
      end
      sit_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = sit_pkg::ST_IDLE;
        end
      end
      default: state_next = sit_pkg::ST_IDLE;
    endcase
  end

  // ring control and head rewrite
  always_comb begin
    ctl.shift = (state == sit_pkg::ST_SCAN) || (state == sit_pkg::ST_PLACE);
    ctl.clear = in_acc && (in_kind_e == sit_pkg::OP_CLEAR);
    head_new  = head;
    case (state)
      sit_pkg::ST_SCAN: begin
        if (match && (kind_r == sit_pkg::OP_SET_TEMP)) begin
          head_new.temp = rd_r;
        end
        if (match && (kind_r == sit_pkg::OP_SET_HUM)) begin
          head_new.hum = rd_r;
        end
      end
      sit_pkg::ST_PLACE: begin
        if (cnt == free_idx) begin
          head_new.id   = key_r;
          head_new.temp = sit_pkg::NO_READING;
          head_new.hum  = sit_pkg::NO_READING;
        end
      end
      default: head_new = head;
    endcase
  end

  always_comb begin
    case (kind_r)
      sit_pkg::OP_ADD:       res_ok = hit || placed;
      sit_pkg::OP_SET_TEMP,
      sit_pkg::OP_SET_HUM,
      sit_pkg::OP_LOOKUP:    res_ok = hit;
      sit_pkg::OP_READ_SLOT: res_ok = pos_ok;
      sit_pkg::OP_CLEAR:     res_ok = 1'b1;
      default:               res_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sit_pkg::ST_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.clear) begin
        fill <= '0;
      end else if ((state == sit_pkg::ST_PLACE) && (cnt == free_idx)) begin
        fill <= fill + FW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r     <= in_kind_e;
      key_r      <= in_id;
      rd_r       <= in_reading;
      pos_r      <= in_pos;
      cnt        <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      free_idx   <= '0;
      placed     <= 1'b0;
      htemp      <= '0;
      hhum       <= '0;
      rid        <= '0;
    end else if (ctl.shift) begin
      cnt <= last ? '0 : cnt + IW'(1);
      if (state == sit_pkg::ST_SCAN) begin
        if (match) begin
          hit   <= 1'b1;
          htemp <= head.temp;
          hhum  <= head.hum;
        end
        if (head_free && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cnt;
        end
        if (8'(cnt) == pos_r) begin
          rid <= head.id;
        end
      end else if (cnt == free_idx) begin
        placed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok   <= res_ok;
      out_temp <= (kind_r == sit_pkg::OP_LOOKUP) ? (hit ? htemp : sit_pkg::NO_READING) : 16'd0;
      out_hum  <= (kind_r == sit_pkg::OP_LOOKUP) ? (hit ? hhum : sit_pkg::NO_READING) : 16'd0;
      out_id   <= ((kind_r == sit_pkg::OP_READ_SLOT) && pos_ok) ? rid : 64'd0;
      out_fill <= 9'(fill);
    end
  end

endmodule

@@ rtl/sensor_id_table.sv @@
// channel | dir | tdata (low bit up)                                  | tuser
// s_*     | in  | sensor_id[63:0] reading[79:64] slot_position[87:80]   | kind[2:0]
// m_*     | out | temperature_out[15:0] humidity_out[31:16]            | ok[0]
//         |     | slot_id_out[95:32] filled_count[104:96]              |
// Slots sit in a ring of cells that rotates one place a cycle past a single
// head compare. Lookup, set and read slot make one lap of the ring; an add that
// inserts makes two (search lap, then placement lap); clear and unused
// kinds skip the ring. Reset and clear empty all cells at once.
// A new word is taken while the previous result waits on m_tready; a result
// held by m_tready stalls the block in its final cycle.
module sensor_id_table #(
  parameter int SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [87:0]  s_tdata,   // sensor_id, reading, slot_position
  input  logic [2:0]   s_tuser,   // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // temperature_out, humidity_out, slot_id_out, filled_count
  output logic [0:0]   m_tuser    // ok
);

  sit_pkg::entry_t    cell_q [SLOTS];
  sit_pkg::entry_t    head_new;
  sit_pkg::cell_ctl_t ctl;

  logic        out_ok;
  logic [15:0] out_temp;
  logic [15:0] out_hum;
  logic [63:0] out_id;
  logic [8:0]  out_fill;

  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      sit_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctl  (ctl),
        .din  ((gi == SLOTS - 1) ? head_new : cell_q[(gi + 1) % SLOTS]),
        .dout (cell_q[gi])
      );
    end
  endgenerate

  sit_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_kind    (s_tuser),
    .in_id      (s_tdata[63:0]),
    .in_reading (s_tdata[79:64]),
    .in_pos     (s_tdata[87:80]),
    .head       (cell_q[0]),
    .head_new   (head_new),
    .ctl        (ctl),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_ok     (out_ok),
    .out_temp   (out_temp),
    .out_hum    (out_hum),
    .out_id     (out_id),
    .out_fill   (out_fill)
  );

  assign m_tdata = {7'd0, out_fill, out_id, out_hum, out_temp};
  assign m_tuser = out_ok;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[104:96] <= 9'(SLOTS)))
    else $error("filled count beyond table size");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared with no word in progress");
`endif

endmodule

@@ dv/sensor_id_table_checker.sv @@
`timescale 1ns / 1ps

module sensor_id_table_checker #(
  parameter int SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [87:0]  s_tdata,   // sensor_id, reading, slot_position
  input  logic [2:0]   s_tuser,   // kind
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,   // temperature_out, humidity_out, slot_id_out, filled_count
  input  logic [0:0]   m_tuser,   // ok
  output int           mismatches,
  output int           replies_owed
);

  typedef struct {
    logic        ok;
    logic [15:0] temperature;
    logic [15:0] humidity;
    logic [63:0] slot_id;
    logic [8:0]  filled;
  } table_reply_t;

  logic [63:0] tbl_id   [SLOTS];
  logic [15:0] tbl_temp [SLOTS];
  logic [15:0] tbl_hum  [SLOTS];
  logic [8:0]  tbl_fill;

  table_reply_t pending_replies[$];
  int           bad;

  task automatic wipe_table();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_id[i]   = '0;
      tbl_temp[i] = '0;
      tbl_hum[i]  = '0;
    end
    tbl_fill = '0;
  endtask

  // slot holding id, or -1; zero never matches
  function automatic int find_sensor(logic [63:0] id);
    int hit;
    hit = -1;
    if (id != '0)
      for (int i = 0; i < SLOTS; i++)
        if (hit < 0 && tbl_id[i] == id) hit = i;
    return hit;
  endfunction

  task automatic predict_table_reply(input logic [2:0] kind, input logic [63:0] id,
                                     input logic [15:0] reading, input logic [7:0] pos,
                                     output table_reply_t r);
    int hit;
    int free_slot;
    int idx;
    r.ok          = 1'b0;
    r.temperature = '0;
    r.humidity    = '0;
    r.slot_id     = '0;
    hit = find_sensor(id);
    idx = int'(pos);
    case (kind)
      sit_pkg::OP_ADD: begin
        if (id != '0) begin
          if (hit >= 0) begin
            r.ok = 1'b1;
          end else begin
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++)
              if (free_slot < 0 && tbl_id[i] == '0) free_slot = i;
            if (free_slot >= 0) begin
              tbl_id[free_slot]   = id;
              tbl_temp[free_slot] = sit_pkg::NO_READING;
              tbl_hum[free_slot]  = sit_pkg::NO_READING;
              tbl_fill            = tbl_fill + 9'd1;
              r.ok = 1'b1;
            end
          end
        end
      end
      sit_pkg::OP_SET_TEMP: begin
        if (hit >= 0) begin
          tbl_temp[hit] = reading;
          r.ok = 1'b1;
        end
      end
      sit_pkg::OP_SET_HUM: begin
        if (hit >= 0) begin
          tbl_hum[hit] = reading;
          r.ok = 1'b1;
        end
      end
      sit_pkg::OP_LOOKUP: begin
        if (hit >= 0) begin
          r.ok          = 1'b1;
          r.temperature = tbl_temp[hit];
          r.humidity    = tbl_hum[hit];
        end else begin
          r.temperature = sit_pkg::NO_READING;
          r.humidity    = sit_pkg::NO_READING;
        end
      end
      sit_pkg::OP_READ_SLOT: begin
        if (idx < SLOTS) begin
          r.ok      = 1'b1;
          r.slot_id = tbl_id[idx];
        end
      end
      sit_pkg::OP_CLEAR: begin
        wipe_table();
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.filled = tbl_fill;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      bad++;
    end
  endtask

  always @(posedge clk) begin
    table_reply_t want;
    if (rst) begin
      wipe_table();
      pending_replies.delete();
      bad = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_replies.size() == 0) begin
          $error("result word with no request outstanding");
          bad++;
        end else begin
          want = pending_replies.pop_front();
          check_field("ok", 64'(want.ok), 64'(m_tuser[0]));
          check_field("temperature_out", 64'(want.temperature), 64'(m_tdata[15:0]));
          check_field("humidity_out", 64'(want.humidity), 64'(m_tdata[31:16]));
          check_field("slot_id_out", want.slot_id, m_tdata[95:32]);
          check_field("filled_count", 64'(want.filled), 64'(m_tdata[104:96]));
        end
      end
      if (s_tvalid && s_tready) begin
        predict_table_reply(s_tuser, s_tdata[63:0], s_tdata[79:64], s_tdata[87:80], want);
        pending_replies.push_back(want);
      end
    end
    mismatches   <= bad;
    replies_owed <= pending_replies.size();
  end

endmodule

@@ dv/sensor_id_table_test.sv @@
`timescale 1ns / 1ps

module sensor_id_table_test;

  localparam int SLOTS = 16;
  localparam int RANDOM_WORDS = 1800;
  localparam int POOL_SIZE = 24;
  // kinds with no operation behind them
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [87:0]  s_tdata;   // sensor_id, reading, slot_position
  logic [2:0]   s_tuser;   // kind
  logic         m_tvalid;
  logic         m_tready;
  logic [111:0] m_tdata;   // temperature_out, humidity_out, slot_id_out, filled_count
  logic [0:0]   m_tuser;   // ok
  int           mismatches;
  int           replies_owed;

  logic         calm;
  int           stall_left;
  logic [63:0]  id_pool[POOL_SIZE];

  sensor_id_table #(.SLOTS(SLOTS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  sensor_id_table_checker #(.SLOTS(SLOTS)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .mismatches   (mismatches),
    .replies_owed (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("sensor_id_table_test: FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] rand_id();
    return {$urandom, $urandom};
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    int r;
    if (rst) begin
      stall_left = 0;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      r = $urandom_range(0, 99);
      stall_left = (r < 85) ? $urandom_range(0, 2) : $urandom_range(9, 59);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_word(input logic [2:0] kind, input logic [63:0] id,
                           input logic [15:0] reading, input logic [7:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {pos, reading, id};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
  endtask

  initial begin
    logic [2:0]  kind;
    logic [63:0] id;
    logic [7:0]  pos;
    int          r;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = sit_pkg::OP_LOOKUP;
    calm       = 1'b0;
    rst        = 1'b1;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = rand_id();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero ID is never present; an all-ones ID is then added, set and looked up
    send_word(sit_pkg::OP_ADD, '0, 16'h1234, 8'd0);
    send_word(sit_pkg::OP_SET_TEMP, '0, 16'h1234, 8'd0);
    send_word(sit_pkg::OP_SET_HUM, '0, 16'h5678, 8'd0);
    send_word(sit_pkg::OP_LOOKUP, '0, '0, 8'd0);
    send_word(sit_pkg::OP_ADD, '1, '0, '1);
    send_word(sit_pkg::OP_ADD, '1, '1, '0);
    send_word(sit_pkg::OP_SET_TEMP, '1, 16'h0000, 8'd0);
    send_word(sit_pkg::OP_SET_HUM, '1, 16'hFFFF, 8'd0);
    send_word(sit_pkg::OP_LOOKUP, '1, '0, 8'd0);
    send_word(sit_pkg::OP_SET_HUM, 64'h8000_0000_0000_0000, 16'hA5A5, 8'd0);
    // fill the table, then one more add must be refused; then slot reads, spare kinds, clear
    for (int i = 1; i < SLOTS; i++) send_word(sit_pkg::OP_ADD, rand_id() | 64'd1, '0, '0);
    send_word(sit_pkg::OP_ADD, 64'h0000_0000_0000_0001, '0, '0);
    send_word(sit_pkg::OP_READ_SLOT, '0, '0, 8'(SLOTS - 1));
    send_word(sit_pkg::OP_READ_SLOT, '0, '0, 8'(SLOTS));
    send_word(sit_pkg::OP_READ_SLOT, '0, '0, 8'hFF);
    send_word(KIND_SPARE_LO, '1, '1, '1);
    send_word(KIND_SPARE_HI, '1, '1, '1);
    send_word(sit_pkg::OP_CLEAR, '0, '0, '0);
    send_word(sit_pkg::OP_LOOKUP, '1, '0, '0);
    wait_for_drain();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n % 400 == 399) wait_for_drain();
      if ($urandom_range(0, 19) == 0) id_pool[$urandom_range(0, POOL_SIZE - 1)] = rand_id();

      r = $urandom_range(0, 99);
      if (r < 28)      kind = sit_pkg::OP_ADD;
      else if (r < 43) kind = sit_pkg::OP_SET_TEMP;
      else if (r < 58) kind = sit_pkg::OP_SET_HUM;
      else if (r < 82) kind = sit_pkg::OP_LOOKUP;
      else if (r < 96) kind = sit_pkg::OP_READ_SLOT;
      else if (r < 97) kind = sit_pkg::OP_CLEAR;
      else             kind = 3'($urandom_range(0, 7));

      r = $urandom_range(0, 99);
      if (r < 85)      id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (r < 97) id = rand_id();
      else             id = '0;

      pos = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, SLOTS + 1));
      send_word(kind, id, 16'($urandom), pos);
    end

    wait_for_drain();
    repeat (4 * SLOTS + 20) @(posedge clk);
    if (mismatches == 0 && replies_owed == 0) begin
      $display("sensor_id_table_test: PASS");
    end else begin
      $display("sensor_id_table_test: FAIL");
    end
    $finish;
  end

endmodule
